/* rtl/slt_pkg.sv */
`timescale 1ns / 1ps
package slt_pkg;
   localparam int POS_BITS_DEF = 32;
   localparam int LINE_BITS_DEF = 24;
   localparam int LEN_BITS_DEF = 16;
   localparam int KEYWORD_MAX_DEF = 6;
   localparam int KW_BITS = 64;

   localparam logic [6:0] K_BANG = 7'd11;
   localparam logic [6:0] K_STAR = 7'd25;
   localparam logic [6:0] K_MINUS = 7'd37;
   localparam logic [6:0] K_SLASH = 7'd41;
   localparam logic [6:0] K_SLASH_EQ = 7'd42;
   localparam logic [6:0] K_DOT = 7'd43;
   localparam logic [6:0] K_STRING = 7'd44;
   localparam logic [6:0] K_NUMBER = 7'd45;
   localparam logic [6:0] K_IDENT = 7'd46;
   localparam logic [6:0] K_KW0 = 7'd47;
   localparam logic [6:0] K_ERROR = 7'd63;
   localparam logic [6:0] K_EOF = 7'd64;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_CHAR = 2'd1;
   localparam logic [1:0] ERR_STR = 2'd2;

   // keyword text right-aligned, with length
   function automatic logic [KW_BITS-1:0] kw_text(input logic [3:0] i);
      logic [KW_BITS-1:0] t;
      begin
         unique case (i)
            4'd0: t = 64'h616e64;
            4'd1: t = 64'h636c617373;
            4'd2: t = 64'h656c7365;
            4'd3: t = 64'h66616c7365;
            4'd4: t = 64'h66756e63;
            4'd5: t = 64'h666f72;
            4'd6: t = 64'h6966;
            4'd7: t = 64'h6e6f6e65;
            4'd8: t = 64'h6f72;
            4'd9: t = 64'h7072696e74;
            4'd10: t = 64'h72657475726e;
            4'd11: t = 64'h7375706572;
            4'd12: t = 64'h74686973;
            4'd13: t = 64'h74727565;
            4'd14: t = 64'h766172;
            default: t = 64'h7768696c65;
         endcase
         return t;
      end
   endfunction

   function automatic logic [3:0] kw_len(input logic [3:0] i);
      logic [3:0] n;
      begin
         unique case (i)
            4'd0, 4'd5, 4'd14: n = 4'd3;
            4'd6, 4'd8: n = 4'd2;
            4'd1, 4'd3, 4'd9, 4'd11, 4'd15: n = 4'd5;
            4'd10: n = 4'd6;
            default: n = 4'd4;
         endcase
         return n;
      end
   endfunction

   typedef struct packed {
      logic [6:0] kind;
      logic [1:0] err;
      logic       flt;
      logic       last;
   } tok_ctl_type;
endpackage

/* rtl/slt_front.sv */
`timescale 1ns / 1ps
module slt_front #(
   parameter int POS_BITS = slt_pkg::POS_BITS_DEF,
   parameter int LINE_BITS = slt_pkg::LINE_BITS_DEF,
   parameter int LEN_BITS = slt_pkg::LEN_BITS_DEF,
   parameter int KEYWORD_MAX = slt_pkg::KEYWORD_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           in_ch,
   input  logic                 in_end,
   output logic                 in_ready,
   output logic [1:0]           o_cnt,
   output slt_pkg::tok_ctl_type o_ctl  [3],
   output logic [POS_BITS-1:0]  o_start[3],
   output logic [LEN_BITS-1:0]  o_len  [3],
   output logic [LINE_BITS-1:0] o_line [3],
   input  logic                 o_room
);
   localparam int WB = 8 * KEYWORD_MAX;
   typedef enum logic [3:0] {
      M_IDLE, M_OP, M_SLASH, M_DOT, M_INT, M_INTDOT, M_FRAC, M_IDENT, M_STRING, M_COMMENT
   } mode_type;

   mode_type             mode_ff, m;
   logic [7:0]           pend_ff, pend;
   logic [WB-1:0]        word_ff, word;
   logic [LEN_BITS-1:0]  len_ff, len;
   logic [POS_BITS-1:0]  start_ff, start, pos_ff;
   logic [LINE_BITS-1:0] line_ff, line;
   logic                 dot_ff, dot;
   logic [1:0]           n;
   slt_pkg::tok_ctl_type ctl[3];
   logic [POS_BITS-1:0]  st[3];
   logic [LEN_BITS-1:0]  ln[3];
   logic [LINE_BITS-1:0] li[3];
   logic                 fire;
   logic [7:0]           c;
   logic                 restart;

   assign in_ready = o_room;
   assign fire = in_valid & o_room;
   assign c = in_ch;

   function automatic logic is_dig(input logic [7:0] x);
      return x >= 8'h30 && x <= 8'h39;
   endfunction
   function automatic logic is_alp(input logic [7:0] x);
      return (x >= 8'h61 && x <= 8'h7a) || (x >= 8'h41 && x <= 8'h5a) || x == 8'h5f;
   endfunction
   function automatic logic [LEN_BITS-1:0] sat(input logic [LEN_BITS-1:0] v,
                                                input logic [1:0] by);
      logic [LEN_BITS:0] s;
      begin
         s = {1'b0, v} + {{(LEN_BITS-1){1'b0}}, by};
         return s[LEN_BITS] ? {LEN_BITS{1'b1}} : s[LEN_BITS-1:0];
      end
   endfunction
   // operator class: 0 none, 1 two-way, 2 three-way, 3 minus
   function automatic logic [1:0] op_cls(input logic [7:0] x, output logic [6:0] base);
      logic [1:0] r;
      begin
         r = 2'd1;
         base = 7'd0;
         unique case (x)
            8'h21: base = slt_pkg::K_BANG;
            8'h3d: base = slt_pkg::K_BANG + 7'd2;
            8'h3c: base = slt_pkg::K_BANG + 7'd4;
            8'h3e: base = slt_pkg::K_BANG + 7'd6;
            8'h25: base = slt_pkg::K_BANG + 7'd8;
            8'h5e: base = slt_pkg::K_BANG + 7'd10;
            8'h7e: base = slt_pkg::K_BANG + 7'd12;
            8'h2a: begin r = 2'd2; base = slt_pkg::K_STAR; end
            8'h26: begin r = 2'd2; base = slt_pkg::K_STAR + 7'd3; end
            8'h7c: begin r = 2'd2; base = slt_pkg::K_STAR + 7'd6; end
            8'h2b: begin r = 2'd2; base = slt_pkg::K_STAR + 7'd9; end
            8'h2d: begin r = 2'd3; base = slt_pkg::K_MINUS; end
            default: r = 2'd0;
         endcase
         return r;
      end
   endfunction

   always_comb begin
      logic [6:0] base, kk, sk;
      logic [1:0] cls, off;
      logic       done, sgl;
      logic [slt_pkg::KW_BITS-1:0] wv;
      m = mode_ff; pend = pend_ff; word = word_ff; len = len_ff; start = start_ff;
      line = line_ff; dot = dot_ff; n = 2'd0; restart = 1'b0;
      base = 7'd0; kk = slt_pkg::K_IDENT; off = 2'd0; sgl = 1'b0; sk = 7'd0;
      cls = 2'd0; done = 1'b0;
      wv = slt_pkg::KW_BITS'(word_ff);
      for (int i = 0; i < 3; i++) begin
         ctl[i] = '0; st[i] = start_ff; ln[i] = len_ff; li[i] = line_ff;
      end
      for (int k = 15; k >= 0; k--)
         if (len_ff <= LEN_BITS'(KEYWORD_MAX) && len_ff == LEN_BITS'(slt_pkg::kw_len(4'(k)))
             && wv == slt_pkg::kw_text(4'(k)))
            kk = slt_pkg::K_KW0 + 7'(k);
      cls = op_cls(pend_ff, base);
      if (in_end) begin
         unique case (mode_ff)
            M_OP: begin ctl[0].kind = base; ln[0] = LEN_BITS'(1); n = 2'd1; end
            M_SLASH: begin ctl[0].kind = slt_pkg::K_SLASH; ln[0] = LEN_BITS'(1); n = 2'd1; end
            M_DOT: begin ctl[0].kind = slt_pkg::K_DOT; ln[0] = LEN_BITS'(1); n = 2'd1; end
            M_INT, M_FRAC: begin
               ctl[0].kind = slt_pkg::K_NUMBER; ctl[0].flt = dot_ff; n = 2'd1;
            end
            M_INTDOT: begin
               ctl[0].kind = slt_pkg::K_NUMBER; ctl[0].flt = dot_ff;
               ctl[1].kind = slt_pkg::K_DOT; st[1] = pos_ff - POS_BITS'(1);
               ln[1] = LEN_BITS'(1); n = 2'd2;
            end
            M_IDENT: begin ctl[0].kind = kk; n = 2'd1; end
            M_STRING: begin
               ctl[0].kind = slt_pkg::K_ERROR; ctl[0].err = slt_pkg::ERR_STR; n = 2'd1;
            end
            default: ;
         endcase
         ctl[n].kind = slt_pkg::K_EOF; st[n] = pos_ff; ln[n] = '0;
         n = n + 2'd1;
      end else begin
         restart = (mode_ff == M_IDLE);
         unique case (mode_ff)
            M_OP: begin
               m = M_IDLE;
               unique case (cls)
                  2'd1: off = (c == 8'h3d) ? 2'd1 : 2'd0;
                  2'd2: off = (c == pend_ff) ? 2'd1 : (c == 8'h3d) ? 2'd2 : 2'd0;
                  2'd3: off = (c == 8'h2d) ? 2'd1 : (c == 8'h3e) ? 2'd2 :
                              (c == 8'h3d) ? 2'd3 : 2'd0;
                  default: off = 2'd0;
               endcase
               ctl[0].kind = base + 7'(off);
               ln[0] = (off != 2'd0) ? LEN_BITS'(2) : LEN_BITS'(1);
               n = 2'd1; restart = (off == 2'd0);
            end
            M_SLASH: begin
               if (c == 8'h2f) m = M_COMMENT;
               else begin
                  m = M_IDLE; n = 2'd1;
                  if (c == 8'h3d) begin
                     ctl[0].kind = slt_pkg::K_SLASH_EQ; ln[0] = LEN_BITS'(2);
                  end else begin
                     ctl[0].kind = slt_pkg::K_SLASH; ln[0] = LEN_BITS'(1); restart = 1'b1;
                  end
               end
            end
            M_DOT: begin
               if (is_dig(c)) begin m = M_FRAC; dot = 1'b1; len = sat(len_ff, 2'd1); end
               else begin
                  m = M_IDLE; ctl[0].kind = slt_pkg::K_DOT; ln[0] = LEN_BITS'(1);
                  n = 2'd1; restart = 1'b1;
               end
            end
            M_INT, M_FRAC: begin
               if (is_dig(c)) len = sat(len_ff, 2'd1);
               else if (c == 8'h2e && mode_ff == M_INT) m = M_INTDOT;
               else begin
                  m = M_IDLE; ctl[0].kind = slt_pkg::K_NUMBER; ctl[0].flt = dot_ff;
                  n = 2'd1; restart = 1'b1;
               end
            end
            M_INTDOT: begin
               if (is_dig(c)) begin m = M_FRAC; dot = 1'b1; len = sat(len_ff, 2'd2); end
               else begin
                  m = M_IDLE; ctl[0].kind = slt_pkg::K_NUMBER; ctl[0].flt = dot_ff;
                  ctl[1].kind = slt_pkg::K_DOT; st[1] = pos_ff - POS_BITS'(1);
                  ln[1] = LEN_BITS'(1); n = 2'd2; restart = 1'b1;
               end
            end
            M_IDENT: begin
               if (is_alp(c) || is_dig(c)) begin
                  if (len_ff < LEN_BITS'(KEYWORD_MAX)) word = {word_ff[WB-9:0], c};
                  len = sat(len_ff, 2'd1);
               end else begin
                  m = M_IDLE; ctl[0].kind = kk; n = 2'd1; restart = 1'b1;
               end
            end
            M_STRING: begin
               len = sat(len_ff, 2'd1);
               if (c == 8'h22) begin
                  m = M_IDLE; ctl[0].kind = slt_pkg::K_STRING; ln[0] = len; n = 2'd1;
               end else if (c == 8'h0a) line = line_ff + LINE_BITS'(1);
            end
            M_COMMENT: if (c == 8'h0a) begin m = M_IDLE; restart = 1'b1; end
            default: begin m = M_IDLE; restart = 1'b1; end
         endcase
         if (restart) begin
            start = pos_ff; len = LEN_BITS'(1); dot = 1'b0; word = '0; m = M_IDLE;
            sgl = 1'b1;
            unique case (c)
               8'h28: sk = 7'd0;  8'h29: sk = 7'd1;  8'h7b: sk = 7'd2;  8'h7d: sk = 7'd3;
               8'h5b: sk = 7'd4;  8'h5d: sk = 7'd5;  8'h2c: sk = 7'd6;  8'h3b: sk = 7'd7;
               8'h3a: sk = 7'd8;  8'h40: sk = 7'd9;  8'h3f: sk = 7'd10;
               default: sgl = 1'b0;
            endcase
            done = 1'b1;
            if (sgl) begin
               ctl[n].kind = sk; st[n] = pos_ff; ln[n] = LEN_BITS'(1); n = n + 2'd1;
            end else if (op_cls(c, base) != 2'd0) begin m = M_OP; pend = c; end
            else if (c == 8'h2f) m = M_SLASH;
            else if (c == 8'h2e) m = M_DOT;
            else if (c == 8'h22) m = M_STRING;
            else if (c == 8'h20 || c == 8'h0d || c == 8'h09) done = 1'b1;
            else if (c == 8'h0a) line = line_ff + LINE_BITS'(1);
            else if (is_dig(c)) m = M_INT;
            else if (is_alp(c)) begin m = M_IDENT; word = WB'(c); end
            else begin
               ctl[n].kind = slt_pkg::K_ERROR; ctl[n].err = slt_pkg::ERR_CHAR;
               st[n] = pos_ff; ln[n] = LEN_BITS'(1); n = n + 2'd1;
            end
         end
      end
      for (int i = 0; i < 3; i++) if (2'(i) + 2'd1 == n) ctl[i].last = done | 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE; pend_ff <= '0; word_ff <= '0; len_ff <= '0; start_ff <= '0;
         pos_ff <= '0; line_ff <= LINE_BITS'(1); dot_ff <= 1'b0;
      end else if (fire) begin
         if (in_end) begin
            mode_ff <= M_IDLE; pend_ff <= '0; word_ff <= '0; len_ff <= '0; start_ff <= '0;
            pos_ff <= '0; line_ff <= LINE_BITS'(1); dot_ff <= 1'b0;
         end else begin
            mode_ff <= m; pend_ff <= pend; word_ff <= word; len_ff <= len;
            start_ff <= start; pos_ff <= pos_ff + POS_BITS'(1); line_ff <= line;
            dot_ff <= dot;
         end
      end
   end

   always_comb begin
      o_cnt = fire ? n : 2'd0;
      for (int i = 0; i < 3; i++) begin
         o_ctl[i] = ctl[i]; o_start[i] = st[i]; o_len[i] = ln[i];
         o_line[i] = li[i];
      end
   end
endmodule

/* rtl/slt_back.sv */
`timescale 1ns / 1ps
module slt_back #(
   parameter int POS_BITS = slt_pkg::POS_BITS_DEF,
   parameter int LINE_BITS = slt_pkg::LINE_BITS_DEF,
   parameter int LEN_BITS = slt_pkg::LEN_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           i_cnt,
   input  slt_pkg::tok_ctl_type i_ctl  [3],
   input  logic [POS_BITS-1:0]  i_start[3],
   input  logic [LEN_BITS-1:0]  i_len  [3],
   input  logic [LINE_BITS-1:0] i_line [3],
   output logic                 i_room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output slt_pkg::tok_ctl_type out_ctl,
   output logic [POS_BITS-1:0]  out_start,
   output logic [LEN_BITS-1:0]  out_len,
   output logic [LINE_BITS-1:0] out_line
);
   localparam int W = 11 + POS_BITS + LEN_BITS + LINE_BITS;
   localparam int DEPTH = 8;
   logic [W-1:0] q_ff[DEPTH];
   logic [2:0]   wr_ff, rd_ff;
   logic [3:0]   cnt_ff;
   logic         pop;

   assign pop = out_valid & out_ready;
   assign out_valid = cnt_ff != 4'd0;
   assign i_room = cnt_ff <= 4'd5;
   assign {out_ctl, out_start, out_len, out_line} = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++)
         if (2'(i) < i_cnt)
            q_ff[wr_ff + 3'(i)] <= {i_ctl[i], i_start[i], i_len[i], i_line[i]};
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_ff + 3'(i_cnt);
         rd_ff <= rd_ff + 3'(pop);
         cnt_ff <= cnt_ff + 4'(i_cnt) - 4'(pop);
      end
   end
endmodule

/* rtl/script_lexer_tokenizer_core.sv */
`timescale 1ns / 1ps
// Streaming lexer: one source byte per item at one item per cycle, end marker flushes and
// emits end of file. A byte yields up to three tokens into an eight-entry queue; input
// stalls exactly when that queue has fewer than three free entries.
module script_lexer_tokenizer_core #(
   parameter int POS_BITS = slt_pkg::POS_BITS_DEF,
   parameter int LINE_BITS = slt_pkg::LINE_BITS_DEF,
   parameter int LEN_BITS = slt_pkg::LEN_BITS_DEF,
   parameter int KEYWORD_MAX = slt_pkg::KEYWORD_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // ch
   input  logic        req_tuser,  // end_marker
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // kind, err, start_pos, tok_len, line_no, is_float, zero fill
   output logic [((10 + POS_BITS + LEN_BITS + LINE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic        rsp_tlast
);
   localparam int DW = ((10 + POS_BITS + LEN_BITS + LINE_BITS + 7) / 8) * 8;
   localparam int UW = 10 + POS_BITS + LEN_BITS + LINE_BITS;
   logic [1:0]           cnt;
   slt_pkg::tok_ctl_type ctl[3];
   logic [POS_BITS-1:0]  st[3];
   logic [LEN_BITS-1:0]  ln[3];
   logic [LINE_BITS-1:0] li[3];
   logic                 room;
   slt_pkg::tok_ctl_type oc;
   logic [POS_BITS-1:0]  os;
   logic [LEN_BITS-1:0]  ol;
   logic [LINE_BITS-1:0] oli;

   slt_front #(.POS_BITS(POS_BITS), .LINE_BITS(LINE_BITS), .LEN_BITS(LEN_BITS),
      .KEYWORD_MAX(KEYWORD_MAX)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ch(req_tdata), .in_end(req_tuser),
      .in_ready(req_tready), .o_cnt(cnt), .o_ctl(ctl), .o_start(st), .o_len(ln),
      .o_line(li), .o_room(room));

   slt_back #(.POS_BITS(POS_BITS), .LINE_BITS(LINE_BITS), .LEN_BITS(LEN_BITS)) u_back (
      .clock, .reset, .i_cnt(cnt), .i_ctl(ctl), .i_start(st), .i_len(ln), .i_line(li),
      .i_room(room), .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_ctl(oc),
      .out_start(os), .out_len(ol), .out_line(oli));

   assign rsp_tdata = DW'({oc.flt, oli, ol, os, oc.err, oc.kind});
   assign rsp_tlast = oc.last;

   a_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> cnt == 2'd0) else $error("tokens pushed while stalled");
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && oc.kind == slt_pkg::K_EOF |-> rsp_tlast) else $error("eof not last");
   a_width: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> oc.kind <= slt_pkg::K_EOF && UW <= DW) else $error("bad kind");
endmodule

/* verif/script_lexer_tokenizer_checker.sv */
`timescale 1ns / 1ps
module script_lexer_tokenizer_checker #(
   parameter int RSP_W = 88
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             rsp_tlast,
   output int               errors,
   output int               pending
);
   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_OP, SCAN_SLASH, SCAN_DOT, SCAN_INT, SCAN_INTDOT,
      SCAN_FRAC, SCAN_IDENT, SCAN_STRING, SCAN_COMMENT
   } scan_mode_type;

   typedef struct {
      logic [6:0]  kind;
      logic [1:0]  err;
      logic [31:0] start_pos;
      logic [15:0] tok_len;
      logic [23:0] line_no;
      logic        is_float;
      logic        last;
   } token_type;

   localparam string PUNCT = "(){}[],;:@?";
   localparam string TWO_OPS = "!=<>%^~";
   localparam string THREE_OPS = "*&|+";
   localparam int KW_MAX = 6;
   localparam logic [7:0] CH_MINUS = "-";
   localparam logic [7:0] CH_EQ = "=";
   localparam logic [7:0] CH_GT = ">";
   localparam logic [7:0] CH_SLASH = "/";
   localparam logic [7:0] CH_DOT = ".";
   localparam logic [7:0] CH_QUOTE = "\"";
   localparam logic [7:0] CH_NL = 8'h0a;

   string keywords [16] = '{"and", "class", "else", "false", "func", "for", "if", "none",
                            "or", "print", "return", "super", "this", "true", "var", "while"};

   scan_mode_type scan_mode;
   logic [7:0]    op_char;
   logic [47:0]   word_bits;
   logic [15:0]   run_len;
   logic [31:0]   run_start;
   logic [31:0]   byte_pos;
   logic [23:0]   line_cnt;
   logic          has_frac;
   token_type     token_q[$];
   int            step_cnt;

   assign pending = token_q.size();

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   // returns number of follow-up forms, base kind through argument
   function automatic int op_class(logic [7:0] c, output logic [6:0] base);
      base = '0;
      for (int i = 0; i < 7; i++)
         if (TWO_OPS[i] == c) begin
            base = slt_pkg::K_BANG + 7'(2 * i);
            return 1;
         end
      for (int i = 0; i < 4; i++)
         if (THREE_OPS[i] == c) begin
            base = slt_pkg::K_STAR + 7'(3 * i);
            return 2;
         end
      if (c == CH_MINUS) begin
         base = slt_pkg::K_MINUS;
         return 3;
      end
      return 0;
   endfunction

   function automatic int op_offset(logic [7:0] p, logic [7:0] c);
      logic [6:0] b;
      case (op_class(p, b))
         1: return c == CH_EQ ? 1 : 0;
         2: return c == p ? 1 : (c == CH_EQ ? 2 : 0);
         3: return c == CH_MINUS ? 1 : (c == CH_GT ? 2 : (c == CH_EQ ? 3 : 0));
         default: return 0;
      endcase
   endfunction

   function void push_token(logic [6:0] kind, logic [1:0] err, logic [31:0] start,
                            logic [15:0] len, logic flt);
      token_type t;
      if (step_cnt >= 3) return;
      t.kind = kind;
      t.err = err;
      t.start_pos = start;
      t.tok_len = len;
      t.line_no = line_cnt;
      t.is_float = flt;
      t.last = 1'b0;
      token_q.insert(token_q.size(), t);
      step_cnt++;
   endfunction

   function void grow(int by);
      run_len = (32'hffff - run_len < by) ? 16'hffff : run_len + 16'(by);
   endfunction

   function void close_number();
      push_token(slt_pkg::K_NUMBER, slt_pkg::ERR_NONE, run_start, run_len, has_frac);
   endfunction

   function void close_word();
      logic [47:0] v;
      if (run_len <= KW_MAX)
         for (int i = 0; i < 16; i++) begin
            v = '0;
            for (int j = 0; j < keywords[i].len(); j++)
               v = {v[39:0], keywords[i][j]};
            if (keywords[i].len() == run_len && v == word_bits) begin
               push_token(slt_pkg::K_KW0 + 7'(i), slt_pkg::ERR_NONE, run_start, run_len,
                          1'b0);
               return;
            end
         end
      push_token(slt_pkg::K_IDENT, slt_pkg::ERR_NONE, run_start, run_len, 1'b0);
   endfunction

   function void clear_scan();
      scan_mode = SCAN_IDLE;
      op_char = '0;
      word_bits = '0;
      run_len = '0;
      run_start = '0;
      byte_pos = '0;
      line_cnt = 24'd1;
      has_frac = 1'b0;
   endfunction

   function void begin_token(logic [7:0] c);
      logic [6:0] b;
      run_start = byte_pos;
      run_len = 16'd1;
      has_frac = 1'b0;
      word_bits = '0;
      scan_mode = SCAN_IDLE;
      for (int i = 0; i < 11; i++)
         if (PUNCT[i] == c) begin
            push_token(7'(i), slt_pkg::ERR_NONE, run_start, 16'd1, 1'b0);
            return;
         end
      if (op_class(c, b) != 0) begin
         scan_mode = SCAN_OP;
         op_char = c;
      end else if (c == CH_SLASH) scan_mode = SCAN_SLASH;
      else if (c == CH_DOT) scan_mode = SCAN_DOT;
      else if (c == CH_QUOTE) scan_mode = SCAN_STRING;
      else if (c == " " || c == 8'h0d || c == 8'h09) ;
      else if (c == CH_NL) line_cnt++;
      else if (is_digit(c)) scan_mode = SCAN_INT;
      else if (is_alpha(c)) begin
         scan_mode = SCAN_IDENT;
         word_bits = {40'd0, c};
      end else push_token(slt_pkg::K_ERROR, slt_pkg::ERR_CHAR, run_start, 16'd1, 1'b0);
   endfunction

   // true when the byte still has to begin a token
   function bit extend_token(logic [7:0] c);
      logic [6:0] b;
      int off;
      case (scan_mode)
         SCAN_OP: begin
            void'(op_class(op_char, b));
            off = op_offset(op_char, c);
            scan_mode = SCAN_IDLE;
            if (off != 0) begin
               push_token(b + 7'(off), slt_pkg::ERR_NONE, run_start, 16'd2, 1'b0);
               return 0;
            end
            push_token(b, slt_pkg::ERR_NONE, run_start, 16'd1, 1'b0);
            return 1;
         end
         SCAN_SLASH: begin
            if (c == CH_SLASH) begin
               scan_mode = SCAN_COMMENT;
               return 0;
            end
            scan_mode = SCAN_IDLE;
            if (c == CH_EQ) begin
               push_token(slt_pkg::K_SLASH_EQ, slt_pkg::ERR_NONE, run_start, 16'd2, 1'b0);
               return 0;
            end
            push_token(slt_pkg::K_SLASH, slt_pkg::ERR_NONE, run_start, 16'd1, 1'b0);
            return 1;
         end
         SCAN_DOT: begin
            if (is_digit(c)) begin
               scan_mode = SCAN_FRAC;
               has_frac = 1'b1;
               grow(1);
               return 0;
            end
            scan_mode = SCAN_IDLE;
            push_token(slt_pkg::K_DOT, slt_pkg::ERR_NONE, run_start, 16'd1, 1'b0);
            return 1;
         end
         SCAN_INT: begin
            if (is_digit(c)) begin
               grow(1);
               return 0;
            end
            if (c == CH_DOT) begin
               scan_mode = SCAN_INTDOT;
               return 0;
            end
            scan_mode = SCAN_IDLE;
            close_number();
            return 1;
         end
         SCAN_INTDOT: begin
            if (is_digit(c)) begin
               scan_mode = SCAN_FRAC;
               has_frac = 1'b1;
               grow(2);
               return 0;
            end
            scan_mode = SCAN_IDLE;
            close_number();
            push_token(slt_pkg::K_DOT, slt_pkg::ERR_NONE, byte_pos - 1, 16'd1, 1'b0);
            return 1;
         end
         SCAN_FRAC: begin
            if (is_digit(c)) begin
               grow(1);
               return 0;
            end
            scan_mode = SCAN_IDLE;
            close_number();
            return 1;
         end
         SCAN_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
               if (run_len < KW_MAX) word_bits = {word_bits[39:0], c};
               grow(1);
               return 0;
            end
            scan_mode = SCAN_IDLE;
            close_word();
            return 1;
         end
         SCAN_STRING: begin
            grow(1);
            if (c == CH_QUOTE) begin
               scan_mode = SCAN_IDLE;
               push_token(slt_pkg::K_STRING, slt_pkg::ERR_NONE, run_start, run_len, 1'b0);
            end else if (c == CH_NL) line_cnt++;
            return 0;
         end
         SCAN_COMMENT: begin
            if (c == CH_NL) begin
               scan_mode = SCAN_IDLE;
               return 1;
            end
            return 0;
         end
         default: begin
            scan_mode = SCAN_IDLE;
            return 1;
         end
      endcase
   endfunction

   function void close_source();
      logic [6:0] b;
      case (scan_mode)
         SCAN_OP: begin
            void'(op_class(op_char, b));
            push_token(b, slt_pkg::ERR_NONE, run_start, 16'd1, 1'b0);
         end
         SCAN_SLASH: push_token(slt_pkg::K_SLASH, slt_pkg::ERR_NONE, run_start, 16'd1, 1'b0);
         SCAN_DOT: push_token(slt_pkg::K_DOT, slt_pkg::ERR_NONE, run_start, 16'd1, 1'b0);
         SCAN_INT, SCAN_FRAC: close_number();
         SCAN_INTDOT: begin
            close_number();
            push_token(slt_pkg::K_DOT, slt_pkg::ERR_NONE, byte_pos - 1, 16'd1, 1'b0);
         end
         SCAN_IDENT: close_word();
         SCAN_STRING: push_token(slt_pkg::K_ERROR, slt_pkg::ERR_STR, run_start, run_len, 1'b0);
         default: ;
      endcase
      push_token(slt_pkg::K_EOF, slt_pkg::ERR_NONE, byte_pos, 16'd0, 1'b0);
   endfunction

   function void scan_item(logic [7:0] c, logic end_mark);
      step_cnt = 0;
      if (end_mark) begin
         close_source();
         clear_scan();
      end else begin
         if (scan_mode == SCAN_IDLE || extend_token(c)) begin_token(c);
         byte_pos++;
      end
      if (step_cnt > 0) token_q[$].last = 1'b1;
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t: token %s got %0h expected %0h", $realtime, field, got, want);
      errors++;
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      token_type t;
      if (reset) begin
         clear_scan();
         token_q.delete();
      end else begin
         if (req_tvalid && req_tready) scan_item(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (token_q.size() == 0) begin
               $display("%0t: token with nothing pending", $realtime);
               errors++;
            end else begin
               t = token_q.pop_front();
               if (rsp_tdata[6:0] != t.kind) report("kind", rsp_tdata[6:0], t.kind);
               if (rsp_tdata[8:7] != t.err) report("err", rsp_tdata[8:7], t.err);
               if (rsp_tdata[40:9] != t.start_pos)
                  report("start_pos", rsp_tdata[40:9], t.start_pos);
               if (rsp_tdata[56:41] != t.tok_len) report("tok_len", rsp_tdata[56:41], t.tok_len);
               if (rsp_tdata[80:57] != t.line_no) report("line_no", rsp_tdata[80:57], t.line_no);
               if (rsp_tdata[81] != t.is_float) report("is_float", rsp_tdata[81], t.is_float);
               if (rsp_tlast != t.last) report("last", rsp_tlast, t.last);
            end
         end
      end
   end
endmodule

/* verif/tb_script_lexer_tokenizer_core.sv */
`timescale 1ns / 1ps
module tb_script_lexer_tokenizer_core;
   localparam int RSP_W = ((10 + 32 + 16 + 24 + 7) / 8) * 8;
   localparam int STALL_LIMIT = 5000;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [7:0]       req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;
   int               errors;
   int               pending;

   bit  quiet_sides;
   bit  hold_sink;
   bit  held_once;
   bit  paused_once;
   int  sent_items;
   byte src_q[$];

   script_lexer_tokenizer_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   script_lexer_tokenizer_checker #(.RSP_W(RSP_W)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .errors(errors), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles with no item moving
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // sink side
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_sink) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_sink = 1'b0;
         end
         gap = quiet_sides ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic send(logic [7:0] c, logic end_mark);
      int gap;
      gap = quiet_sides ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tuser <= end_mark;
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   task automatic add_byte(logic [7:0] c);
      src_q.insert(src_q.size(), c);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // one random character out of the set
   task automatic add_pick(string set);
      add_byte(set[$urandom_range(0, set.len() - 1)]);
   endtask

   task automatic push_source(bit closed);
      while (src_q.size() > 0) send(src_q.pop_front(), 1'b0);
      if (closed) send(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic add_random_token();
      case ($urandom_range(0, 11))
         0: add_pick("(){}[],;:@?");
         1: begin
            add_pick("!=<>%^~*&|+-");
            if ($urandom_range(0, 1)) add_pick("=->*&|+x");
         end
         2: add_text(u_checker.keywords[$urandom_range(0, 15)]);
         3: begin
            add_pick("aZ_qkw");
            repeat ($urandom_range(0, 7)) add_pick("aeiouxyzAQ_019");
         end
         4: begin
            repeat ($urandom_range(1, 4)) add_pick("0123456789");
            if ($urandom_range(0, 1)) begin
               add_text(".");
               repeat ($urandom_range(0, 3)) add_pick("0123456789");
            end
         end
         5: begin
            if ($urandom_range(0, 1)) add_text(".7");
            else add_text(".");
         end
         6: begin
            add_text("\"");
            repeat ($urandom_range(0, 5)) add_pick("ab \n/.1");
            if ($urandom_range(0, 5) != 0) add_text("\"");
         end
         7: add_text("// note\n");
         8: add_pick(" \t\r\n");
         9: begin
            if ($urandom_range(0, 1)) add_text("/");
            else add_text("/=");
         end
         10: add_byte(8'($urandom_range(0, 255)));
         default: add_text(" ");
      endcase
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      quiet_sides = 1'b0;
      hold_sink = 1'b0;
      held_once = 1'b0;
      paused_once = 1'b0;
      sent_items = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed
      add_text("(){}[],;:@?!!=<<=>>=%%=^^=~~=**&&&=||+++=");
      push_source(1'b1);
      add_text("- -- -> -= = == / /= // x\n.5 12.75 3.x 7. 42 and class else false");
      add_text(" func for if none or print return super this true var while ab_9cdef");
      push_source(1'b1);
      add_text("\"hi\nyo\" ");
      add_byte(8'h00);
      add_byte(8'h80);
      add_byte(8'hff);
      add_byte(8'h7f);
      add_text("1.");
      push_source(1'b1);
      add_text("\"open");
      push_source(1'b1);

      // random sources with a long sink hold and a sender pause along the way
      while (sent_items < 300) begin
         quiet_sides = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(1, 6)) add_random_token();
         if (!held_once && sent_items > 220) begin
            hold_sink = 1'b1;
            held_once = 1'b1;
         end
         push_source($urandom_range(0, 3) == 0);
         if (!paused_once && sent_items > 260) begin
            paused_once = 1'b1;
            req_tvalid <= 1'b0;
            while (pending != 0) @(posedge clock);
         end
      end
      quiet_sides = 1'b0;

      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
